>>> rtl/lspe_pkg.sv
// ----------------------------------------------------------------------------
// lspe_pkg
// Shared types and codes for the hidden payload extractor.
// ----------------------------------------------------------------------------
package lspe_pkg;

	localparam logic [2:0] KIND_EXT       = 3'd0;
	localparam logic [2:0] KIND_PAY       = 3'd1;
	localparam logic [2:0] KIND_MAGIC_ERR = 3'd2;
	localparam logic [2:0] KIND_LEN_ERR   = 3'd3;
	localparam logic [2:0] KIND_EMPTY     = 3'd4;

	localparam logic [1:0] REG_HEADER_LENGTH  = 2'd0;
	localparam logic [1:0] REG_MAGIC_FIRST    = 2'd1;
	localparam logic [1:0] REG_MAGIC_SECOND   = 2'd2;
	localparam logic [1:0] REG_MAX_EXT_LENGTH = 2'd3;

	localparam logic [15:0] HEADER_LENGTH_RST = 16'd54;
	localparam logic [7:0]  MAGIC_FIRST_RST   = 8'h23;
	localparam logic [7:0]  MAGIC_SECOND_RST  = 8'h2A;
	localparam logic [7:0]  MAX_EXT_RST       = 8'd255;

	typedef struct packed {
		logic [15:0] header_length;
		logic [7:0]  magic_first;
		logic [7:0]  magic_second;
		logic [7:0]  max_extension_length;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [2:0] kind;
		logic       last;
	} res_t;

endpackage

>>> rtl/lsb_stego_payload_extractor_top.sv
// ----------------------------------------------------------------------------
// lsb_stego_payload_extractor_top
// Recovers a hidden frame from the least significant bits of image bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Image bytes enter on the s_ stream, one per transaction; s_tuser marks
//   the first byte of a new image and restarts decoding. Decoded extension
//   and payload bytes, and single error or empty-payload status results,
//   leave on the m_ stream with the kind in m_tuser and m_tlast on the
//   final result of a frame. Most input bytes give no result.
//   A byte is taken into the input register, then decoded into the result
//   register, from which its result is presented.
//   Throughput: one byte per cycle, sustained, while m_tready is high.
//   When the receiver stalls, the result register holds; one more byte
//   waits in the input register, then s_tready drops.
//   Registers are written through cfg_wr_en/cfg_addr/cfg_wdata and should
//   only change while no byte is in flight.
//   Reset clears both stream stages, restores register defaults and puts
//   the decoder in header skip, so decoding starts without a frame mark.
// ----------------------------------------------------------------------------
module lsb_stego_payload_extractor_top
	import lspe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] image_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast
);

	cfg_t       cfg_q;
	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       in_start_s1;
	logic       out_valid_s2;
	logic [7:0] out_data_s2;
	logic [2:0] out_kind_s2;
	logic       out_last_s2;
	logic       advance;
	res_t       res;

	assign advance  = !out_valid_s2 || m_tready;
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{header_length: HEADER_LENGTH_RST, magic_first: MAGIC_FIRST_RST,
				magic_second: MAGIC_SECOND_RST, max_extension_length: MAX_EXT_RST};
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_HEADER_LENGTH:  cfg_q.header_length        <= cfg_wdata;
				REG_MAGIC_FIRST:    cfg_q.magic_first          <= cfg_wdata[7:0];
				REG_MAGIC_SECOND:   cfg_q.magic_second         <= cfg_wdata[7:0];
				REG_MAX_EXT_LENGTH: cfg_q.max_extension_length <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	lspe_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.step        (in_valid_s1 && advance),
		.image_byte  (in_byte_s1),
		.frame_start (in_start_s1),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				in_valid_s1 <= 1'b1;
			else if (advance)
				in_valid_s1 <= 1'b0;
			if (advance)
				out_valid_s2 <= in_valid_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1  <= s_tdata;
			in_start_s1 <= s_tuser;
		end
		if (advance) begin
			out_data_s2 <= res.data;
			out_kind_s2 <= res.kind;
			out_last_s2 <= res.last;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = out_data_s2;
	assign m_tuser  = out_kind_s2;
	assign m_tlast  = out_last_s2;

endmodule

>>> rtl/lspe_core.sv
// ----------------------------------------------------------------------------
// lspe_core
// Frame state and one-byte decode step: bit collection, magic and length
// checks, byte emission.
// ----------------------------------------------------------------------------
module lspe_core
	import lspe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step,
	input  logic [7:0] image_byte,
	input  logic       frame_start,
	output res_t       res
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_MAGIC  = 3'd1;
	localparam logic [2:0] PH_EXTLEN = 3'd2;
	localparam logic [2:0] PH_EXT    = 3'd3;
	localparam logic [2:0] PH_PAYLEN = 3'd4;
	localparam logic [2:0] PH_PAY    = 3'd5;
	localparam logic [2:0] PH_IDLE   = 3'd6;

	logic [2:0]  phase_q, phase_d;
	logic [15:0] hcount_q, hcount_d;
	logic [4:0]  bcount_q, bcount_d;
	logic [31:0] shift_q, shift_d;
	logic [30:0] remain_q, remain_d;
	logic        magic_bad_q, magic_bad_d;

	always_comb begin
		phase_d     = frame_start ? PH_HEADER : phase_q;
		hcount_d    = frame_start ? 16'd0 : hcount_q;
		bcount_d    = frame_start ? 5'd0 : bcount_q;
		shift_d     = frame_start ? 32'd0 : shift_q;
		remain_d    = frame_start ? 31'd0 : remain_q;
		magic_bad_d = frame_start ? 1'b0 : magic_bad_q;
		res         = '0;

		if (phase_d < PH_IDLE) begin
			if (phase_d == PH_HEADER && hcount_d < cfg.header_length) begin
				hcount_d = hcount_d + 16'd1;
			end else begin
				if (phase_d == PH_HEADER) begin
					phase_d  = PH_MAGIC;
					bcount_d = 5'd0;
				end
				shift_d = {shift_d[30:0], image_byte[0]};
				unique case (phase_d)
					PH_MAGIC: begin
						if (bcount_d == 5'd7)
							magic_bad_d = (shift_d[7:0] != cfg.magic_first);
						if (bcount_d != 5'd15) begin
							bcount_d = bcount_d + 5'd1;
						end else begin
							bcount_d = 5'd0;
							if (magic_bad_d || shift_d[7:0] != cfg.magic_second) begin
								phase_d = PH_IDLE;
								res     = '{valid: 1'b1, data: 8'd0,
									kind: KIND_MAGIC_ERR, last: 1'b1};
							end else begin
								phase_d = PH_EXTLEN;
							end
						end
					end
					PH_EXTLEN, PH_PAYLEN: begin
						if (bcount_d != 5'd31) begin
							bcount_d = bcount_d + 5'd1;
						end else begin
							bcount_d = 5'd0;
							if (shift_d[31] || (phase_d == PH_EXTLEN &&
								shift_d[30:0] > {23'd0, cfg.max_extension_length})) begin
								phase_d = PH_IDLE;
								res     = '{valid: 1'b1, data: 8'd0,
									kind: KIND_LEN_ERR, last: 1'b1};
							end else begin
								remain_d = shift_d[30:0];
								if (phase_d == PH_EXTLEN) begin
									phase_d = (shift_d[30:0] == 31'd0) ? PH_PAYLEN : PH_EXT;
								end else if (shift_d[30:0] == 31'd0) begin
									phase_d = PH_IDLE;
									res     = '{valid: 1'b1, data: 8'd0,
										kind: KIND_EMPTY, last: 1'b1};
								end else begin
									phase_d = PH_PAY;
								end
							end
						end
					end
					PH_EXT, PH_PAY: begin
						if (bcount_d != 5'd7) begin
							bcount_d = bcount_d + 5'd1;
						end else begin
							bcount_d = 5'd0;
							if (remain_d != 31'd0)
								remain_d = remain_d - 31'd1;
							if (phase_d == PH_EXT) begin
								if (remain_d == 31'd0)
									phase_d = PH_PAYLEN;
								res = '{valid: 1'b1, data: shift_d[7:0],
									kind: KIND_EXT, last: 1'b0};
							end else begin
								if (remain_d == 31'd0)
									phase_d = PH_IDLE;
								res = '{valid: 1'b1, data: shift_d[7:0],
									kind: KIND_PAY, last: (remain_d == 31'd0)};
							end
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hcount_q    <= '0;
			bcount_q    <= '0;
			shift_q     <= '0;
			remain_q    <= '0;
			magic_bad_q <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			hcount_q    <= hcount_d;
			bcount_q    <= bcount_d;
			shift_q     <= shift_d;
			remain_q    <= remain_d;
			magic_bad_q <= magic_bad_d;
		end
	end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hidden payload extractor.
// Builds carrier images with frames hidden in the pixel LSBs: good, broken,
// truncated and noisy. Every byte taken by the block is fed to a predictor
// that decodes it the same way. Each result that leaves the block is checked
// field by field against the oldest predicted one. Both streams stall at
// random, and the register settings change between runs of frames.
// ----------------------------------------------------------------------------
module tb;
	import lspe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		ST_SKIP, ST_MAGIC, ST_EXTLEN, ST_EXT, ST_PAYLEN, ST_PAY, ST_IDLE
	} decode_st_e;

	typedef struct packed {
		logic [7:0] pix;
		logic       st;
	} img_t;

	class hidden_frame_checker;
		cfg_t        cfg;
		decode_st_e  st;
		logic [15:0] hdr_cnt;
		logic [4:0]  bit_cnt;
		logic [31:0] shreg;
		logic [31:0] remain;
		logic        magic_fail;
		res_t        due_results[$];
		int          errors;
		int          results_total;

		function new();
			cfg.header_length        = HEADER_LENGTH_RST;
			cfg.magic_first          = MAGIC_FIRST_RST;
			cfg.magic_second         = MAGIC_SECOND_RST;
			cfg.max_extension_length = MAX_EXT_RST;
			errors        = 0;
			results_total = 0;
			restart();
		endfunction

		function void restart();
			st         = ST_SKIP;
			hdr_cnt    = '0;
			bit_cnt    = '0;
			shreg      = '0;
			remain     = '0;
			magic_fail = 1'b0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_HEADER_LENGTH:  cfg.header_length        = val;
				REG_MAGIC_FIRST:    cfg.magic_first          = val[7:0];
				REG_MAGIC_SECOND:   cfg.magic_second         = val[7:0];
				REG_MAX_EXT_LENGTH: cfg.max_extension_length = val[7:0];
				default: ;
			endcase
		endfunction

		function void add(logic [7:0] d, logic [2:0] k, logic l);
			due_results.push_back('{1'b1, d, k, l});
			results_total++;
		endfunction

		function void take_image_byte(logic [7:0] pix, logic start);
			if (start)
				restart();
			if (st == ST_IDLE)
				return;
			if (st == ST_SKIP) begin
				if (hdr_cnt < cfg.header_length) begin
					hdr_cnt++;
					return;
				end
				st      = ST_MAGIC;
				bit_cnt = '0;
			end
			shreg = {shreg[30:0], pix[0]};
			case (st)
				ST_MAGIC: begin
					if (bit_cnt == 5'd7)
						magic_fail = (shreg[7:0] != cfg.magic_first);
					if (bit_cnt != 5'd15) begin
						bit_cnt++;
						return;
					end
					bit_cnt = '0;
					if (magic_fail || shreg[7:0] != cfg.magic_second) begin
						st = ST_IDLE;
						add(8'h00, KIND_MAGIC_ERR, 1'b1);
					end else begin
						st = ST_EXTLEN;
					end
				end
				ST_EXTLEN, ST_PAYLEN: begin
					if (bit_cnt != 5'd31) begin
						bit_cnt++;
						return;
					end
					bit_cnt = '0;
					if (shreg[31] || (st == ST_EXTLEN && shreg > cfg.max_extension_length)) begin
						st = ST_IDLE;
						add(8'h00, KIND_LEN_ERR, 1'b1);
					end else begin
						remain = shreg;
						if (st == ST_EXTLEN) begin
							st = (shreg == 0) ? ST_PAYLEN : ST_EXT;
						end else if (shreg == 0) begin
							st = ST_IDLE;
							add(8'h00, KIND_EMPTY, 1'b1);
						end else begin
							st = ST_PAY;
						end
					end
				end
				ST_EXT, ST_PAY: begin
					if (bit_cnt != 5'd7) begin
						bit_cnt++;
						return;
					end
					bit_cnt = '0;
					if (remain != 0)
						remain--;
					if (st == ST_EXT) begin
						if (remain == 0)
							st = ST_PAYLEN;
						add(shreg[7:0], KIND_EXT, 1'b0);
					end else if (remain == 0) begin
						st = ST_IDLE;
						add(shreg[7:0], KIND_PAY, 1'b1);
					end else begin
						add(shreg[7:0], KIND_PAY, 1'b0);
					end
				end
				default: st = ST_IDLE;
			endcase
		endfunction

		function void match_result(logic [7:0] d, logic [2:0] k, logic l);
			res_t e;
			if (due_results.size() == 0) begin
				$error("unexpected result: out_byte %02h kind %0d is_last %0b", d, k, l);
				errors++;
				return;
			end
			e = due_results.pop_front();
			if (d !== e.data) begin
				$error("out_byte: expected %02h, got %02h", e.data, d);
				errors++;
			end
			if (k !== e.kind) begin
				$error("kind: expected %0d, got %0d", e.kind, k);
				errors++;
			end
			if (l !== e.last) begin
				$error("is_last: expected %0b, got %0b", e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_addr;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	hidden_frame_checker chk = new();

	img_t       img_q[$];
	logic [7:0] content_q[$];
	bit         mark_next;
	int         hidden_left;
	int         hidden_items;
	bit         tx_gaps;
	bit         rx_noisy;
	bit         hold_req;

	lsb_stego_payload_extractor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				chk.take_image_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready)
				chk.match_result(m_tdata, m_tuser, m_tlast);
		end
	end

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (200) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!rx_noisy || $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	function automatic void push_raw(logic [7:0] pix);
		img_q.push_back('{pix, mark_next});
		mark_next = 1'b0;
	endfunction

	function automatic void push_bits(logic [31:0] v, int n);
		logic [7:0] r;
		for (int i = n - 1; i >= 0; i--) begin
			if (hidden_left == 0)
				return;
			hidden_left--;
			hidden_items++;
			r    = 8'($urandom);
			r[0] = v[i];
			push_raw(r);
		end
	endfunction

	function automatic logic [7:0] next_content();
		if (content_q.size() != 0)
			return content_q.pop_front();
		return 8'($urandom);
	endfunction

	// header, magic, extension length and bytes, payload length and bytes;
	// cut >= 0 keeps only that many bit-carrying bytes
	function automatic void build_frame(bit mark, int hdr, logic [7:0] m1, logic [7:0] m2,
		logic [31:0] elen, int ne, logic [31:0] plen, int np, int cut);
		mark_next   = mark;
		hidden_left = (cut < 0) ? 32'h7fff_ffff : cut;
		for (int i = 0; i < hdr; i++)
			push_raw(8'($urandom));
		push_bits(m1, 8);
		push_bits(m2, 8);
		push_bits(elen, 32);
		for (int i = 0; i < ne; i++)
			push_bits(next_content(), 8);
		push_bits(plen, 32);
		for (int i = 0; i < np; i++)
			push_bits(next_content(), 8);
		mark_next = 1'b0;
	endfunction

	function automatic void build_random_frame();
		int          r;
		int          emax;
		int          mx;
		bit          mark;
		logic [7:0]  m1;
		logic [7:0]  m2;
		logic [31:0] elen;
		logic [31:0] plen;
		int          ne;
		int          np;
		int          cut;
		r    = $urandom_range(0, 99);
		mx   = chk.cfg.max_extension_length;
		emax = (mx < 3) ? mx : 3;
		mark = ($urandom_range(0, 15) != 0);
		m1   = chk.cfg.magic_first;
		m2   = chk.cfg.magic_second;
		elen = $urandom_range(0, emax);
		plen = $urandom_range(0, 6);
		ne   = elen;
		np   = plen;
		cut  = -1;
		if (r < 70) begin
		end else if (r < 76) begin
			if ($urandom_range(0, 1))
				m1 = m1 ^ 8'($urandom_range(1, 255));
			else
				m2 = m2 ^ 8'($urandom_range(1, 255));
			cut = 16;
		end else if (r < 82) begin
			if (mx == 255 || $urandom_range(0, 1))
				elen = {1'b1, 31'($urandom)};
			else
				elen = $urandom_range(mx + 1, 255);
			cut = 48;
		end else if (r < 86) begin
			plen = {1'b1, 31'($urandom)};
			np   = 0;
			cut  = 80 + 8 * ne;
		end else if (r < 94) begin
			cut = $urandom_range(0, 79 + 8 * (ne + np));
		end else begin
			repeat ($urandom_range(1, 12))
				img_q.push_back('{8'($urandom), $urandom_range(0, 7) == 0});
			return;
		end
		build_frame(mark, chk.cfg.header_length, m1, m2, elen, ne, plen, np, cut);
		repeat ($urandom_range(0, 3))
			push_raw(8'($urandom));
	endfunction

	task automatic send_image();
		img_t it;
		while (img_q.size() != 0) begin
			it = img_q.pop_front();
			s_tdata  <= it.pix;
			s_tuser  <= it.st;
			s_tvalid <= 1'b1;
			do @(posedge clk); while (!s_tready);
			if (tx_gaps && $urandom_range(0, 9) < 3) begin
				s_tvalid <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (chk.due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_one(logic [1:0] idx, logic [15:0] val);
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		chk.write_reg(idx, val);
	endtask

	task automatic load_config(logic [15:0] hl, logic [7:0] m1, logic [7:0] m2,
		logic [7:0] mx);
		cfg_wr_en <= 1'b1;
		write_one(REG_HEADER_LENGTH, hl);
		write_one(REG_MAGIC_FIRST, {8'h00, m1});
		write_one(REG_MAGIC_SECOND, {8'h00, m2});
		write_one(REG_MAX_EXT_LENGTH, {8'h00, mx});
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int          rnd_base;
		int          start_items;
		int          r;
		logic [15:0] hl;
		logic [7:0]  mx;
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_addr  <= '0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		mark_next = 1'b0;
		hold_req  = 1'b0;
		tx_gaps   = 1'b1;
		rx_noisy  = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings; first frame carries no start mark
		content_q = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
		build_frame(1'b0, 54, 8'h23, 8'h2A, 1, 1, 3, 3, -1);
		repeat (3) push_raw(8'($urandom));
		build_frame(1'b1, 54, 8'h23, 8'h2A, 0, 0, 2, 2, -1);
		send_image();
		wait_idle();

		load_config(16'd2, 8'h23, 8'h2A, 8'hFF);
		build_frame(1'b1, 2, 8'h23, 8'h2A, 2, 2, 0, 0, -1);
		build_frame(1'b1, 2, 8'h24, 8'h2A, 0, 0, 1, 1, 16);
		build_frame(1'b1, 2, 8'h23, 8'h2B, 0, 0, 1, 1, 16);
		build_frame(1'b1, 2, 8'h23, 8'h2A, 32'h8000_0001, 0, 1, 1, 48);
		build_frame(1'b1, 2, 8'h23, 8'h2A, 256, 0, 1, 1, 48);
		build_frame(1'b1, 2, 8'h23, 8'h2A, 0, 0, 32'hFFFF_FFFF, 0, 80);
		build_frame(1'b1, 2, 8'h23, 8'h2A, 1, 1, 5, 2, -1);
		build_frame(1'b1, 2, 8'h23, 8'h2A, 1, 1, 1, 1, -1);
		send_image();
		wait_idle();

		// long receiver hold-off while the sender keeps offering bytes
		load_config(16'd0, 8'h00, 8'hFF, 8'h00);
		tx_gaps  = 1'b0;
		hold_req = 1'b1;
		build_frame(1'b1, 0, 8'h00, 8'hFF, 0, 0, 2, 2, -1);
		build_frame(1'b1, 0, 8'h00, 8'hFF, 1, 0, 1, 1, 48);
		send_image();
		wait_idle();
		tx_gaps = 1'b1;

		load_config(16'd0, 8'hFF, 8'h00, 8'hFF);
		build_frame(1'b1, 0, 8'hFF, 8'h00, 255, 0, 1, 1, 48);
		send_image();
		wait_idle();

		// long header, sent back to back
		load_config(16'd100, 8'h23, 8'h2A, 8'hFF);
		tx_gaps = 1'b0;
		build_frame(1'b1, 100, 8'h23, 8'h2A, 0, 0, 2, 2, -1);
		send_image();
		wait_idle();

		rnd_base     = chk.results_total;
		hidden_items = 0;
		for (int p = 0; p < 3 || hidden_items < 200 || chk.results_total - rnd_base < 15;
			p++) begin
			r  = $urandom_range(0, 99);
			hl = (r < 60) ? 16'($urandom_range(0, 4)) :
				(r < 90) ? 16'($urandom_range(5, 20)) : 16'd54;
			r  = $urandom_range(0, 99);
			mx = (r < 30) ? 8'($urandom_range(0, 3)) : (r < 60) ? 8'hFF : 8'($urandom);
			load_config(hl, 8'($urandom), 8'($urandom), mx);
			tx_gaps  = (p % 4 != 3);
			rx_noisy = (p % 3 != 2);
			start_items = hidden_items;
			while (hidden_items - start_items < 60)
				build_random_frame();
			send_image();
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (chk.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
